// File: rtl/ilp_pkg.sv
// Shared types, constants and a helper function for the integer literal parser.
package ilp_pkg;

    localparam int VALUE_W = 32;
    localparam int PROD_W = VALUE_W + 5;
    localparam int ERR_W = 6;
    localparam logic [ERR_W-1:0] ERR_MAX = 6'd63;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_APOS = 8'h27;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UB = 8'h42;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_UZ = 8'h5A;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LB = 8'h62;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_LZ = 8'h7A;
    localparam logic [7:0] HEX_OFFSET = 8'd10;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_BIN = 2'd1,
        BASE_HEX = 2'd2
    } base_e_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ZERO   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_e_t;

    typedef enum logic {
        CMD_DIGIT  = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_op_e_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         base_code;
        logic               overflow;
        logic               bad_digit;
        logic               binary_range_error;
        logic               no_digits;
        logic [ERR_W-1:0]   error_count;
    } out_item_t;

    // One command from the classifier to the accumulator.
    typedef struct packed {
        cmd_op_e_t  op;
        logic       clear;
        base_e_t    base;
        logic [7:0] digit;
        logic       bad;
        logic       bin_err;
        logic       have_digits;
    } cmd_t;

    function automatic logic [ERR_W-1:0] err_add(input logic [ERR_W-1:0] a,
                                                 input logic [1:0] b);
        logic [ERR_W:0] sum;
        sum = {1'b0, a} + {{(ERR_W-1){1'b0}}, b};
        if (sum > {1'b0, ERR_MAX}) begin
            return ERR_MAX;
        end
        return sum[ERR_W-1:0];
    endfunction

endpackage

// File: rtl/integer_literal_parser_top.sv
// Path: a terminating byte's finish command is written into the command queue, then the result
// is registered in the output register and shown on m_.
// Throughput: one byte per cycle while the command queue is not full; the two-entry command queue
// and the output register let the classifier keep taking bytes while a result waits on m_ready.
// Reset: synchronous active-low aresetn clears parser state, queue and m_valid.
// Top level of the integer literal parser.
module integer_literal_parser_top
    import ilp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic q_push, q_full, q_pop, q_not_empty;
    cmd_t q_in, q_out;

    ilp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    ilp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    ilp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/ilp_front.sv
// Byte classifier: tracks prefix and base, and issues digit and finish commands.
module ilp_front
    import ilp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_data
);

    phase_e_t phase_reg, phase_next;
    base_e_t  base_reg, base_next;
    logic     have_reg, have_next;
    logic     pend_reg, pend_next;

    logic       in_fire;
    logic       lp_go;
    base_e_t    lp_base;
    logic       lp_have;
    logic       lp_clear;
    logic [7:0] ch;
    logic       is_dec, is_lhex, is_uhex, is_alnum;
    logic [7:0] dval;
    logic       dbad;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;
    assign ch = s_data.ch;

    assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_lhex = (ch >= CH_LA) && (ch <= CH_LF);
    assign is_uhex = (ch >= CH_UA) && (ch <= CH_UF);
    assign is_alnum = is_dec || ((ch >= CH_LA) && (ch <= CH_LZ))
                    || ((ch >= CH_UA) && (ch <= CH_UZ));

    // A byte that is not a digit of the base keeps its raw code as the digit value.
    always_comb begin
        dval = ch;
        dbad = 1'b1;
        if (is_dec) begin
            dval = ch - CH_ZERO;
            dbad = 1'b0;
        end else if (lp_base == BASE_HEX && is_lhex) begin
            dval = ch - CH_LA + HEX_OFFSET;
            dbad = 1'b0;
        end else if (lp_base == BASE_HEX && is_uhex) begin
            dval = ch - CH_UA + HEX_OFFSET;
            dbad = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            base_reg  <= BASE_DEC;
            have_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            have_reg  <= have_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        base_next  = base_reg;
        have_next  = have_reg;
        pend_next  = pend_reg;
        lp_go      = 1'b0;
        lp_base    = base_reg;
        lp_have    = have_reg;
        lp_clear   = pend_reg;
        q_push     = 1'b0;
        q_data     = '{op: CMD_DIGIT, clear: lp_clear, base: lp_base, digit: dval,
                       bad: dbad, bin_err: 1'b0, have_digits: lp_have};
        if (in_fire) begin
            if (s_data.start_req) begin
                // The accumulator is cleared with the first command of the new literal.
                pend_next = 1'b1;
                base_next = BASE_DEC;
                have_next = 1'b0;
                if (ch == CH_ZERO) begin
                    phase_next = PH_ZERO;
                    have_next  = 1'b1;
                end else begin
                    phase_next = PH_DIGITS;
                    lp_go      = 1'b1;
                    lp_base    = BASE_DEC;
                    lp_have    = 1'b0;
                    lp_clear   = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                    end
                    PH_ZERO: begin
                        phase_next = PH_DIGITS;
                        if (ch == CH_LB || ch == CH_UB) begin
                            base_next = BASE_BIN;
                            have_next = 1'b0;
                        end else if (ch == CH_LX || ch == CH_UX) begin
                            base_next = BASE_HEX;
                            have_next = 1'b0;
                        end else begin
                            lp_go = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        lp_go = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if (lp_go && ch != CH_APOS) begin
            q_push = 1'b1;
            q_data.clear = lp_clear;
            q_data.base = lp_base;
            q_data.have_digits = lp_have;
            q_data.digit = dval;
            q_data.bad = dbad;
            pend_next = 1'b0;
            if (!is_alnum) begin
                q_data.op  = CMD_FINISH;
                q_data.bad = 1'b0;
                phase_next = PH_IDLE;
            end else begin
                q_data.op      = CMD_DIGIT;
                q_data.bin_err = (lp_base == BASE_BIN) && (dval >= 8'd2);
                have_next      = 1'b1;
            end
        end
    end

endmodule

// File: rtl/ilp_fifo.sv
// Short command queue between the classifier and the accumulator.
module ilp_fifo
    import ilp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t pop_data
);

    cmd_t                 mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH)) ? 1'b1 : 1'b0;
    assign not_empty = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/ilp_back.sv
// Accumulator: multiplies in digits, tracks error flags and registers each result.
module ilp_back
    import ilp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  cmd_t      q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [VALUE_W-1:0] accum_reg;
    logic               ovf_reg;
    logic               bad_reg;
    logic               bin_reg;
    logic [ERR_W-1:0]   cnt_reg;
    logic               m_valid_reg;
    out_item_t          out_reg;

    logic [VALUE_W-1:0] acc_cur;
    logic               ovf_cur, bad_cur, bin_cur;
    logic [ERR_W-1:0]   cnt_cur;
    logic [PROD_W-1:0]  acc_ext;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  sum;
    logic               no_dig;

    assign acc_cur = q_data.clear ? '0 : accum_reg;
    assign ovf_cur = q_data.clear ? 1'b0 : ovf_reg;
    assign bad_cur = q_data.clear ? 1'b0 : bad_reg;
    assign bin_cur = q_data.clear ? 1'b0 : bin_reg;
    assign cnt_cur = q_data.clear ? '0 : cnt_reg;
    assign acc_ext = PROD_W'(acc_cur);
    assign no_dig = !q_data.have_digits;

    // Constant-base multiply as shifts; decimal is x8 plus x2.
    always_comb begin
        unique case (q_data.base)
            BASE_BIN: prod = acc_ext << 1;
            BASE_HEX: prod = acc_ext << 4;
            default:  prod = (acc_ext << 3) + (acc_ext << 1);
        endcase
        sum = prod + PROD_W'(q_data.digit);
    end

    assign q_pop = q_valid && (q_data.op == CMD_DIGIT || !m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            if (q_data.op == CMD_DIGIT) begin
                accum_reg <= sum[VALUE_W-1:0];
                ovf_reg   <= ovf_cur || (sum[PROD_W-1:VALUE_W] != '0);
                bad_reg   <= bad_cur || q_data.bad;
                bin_reg   <= bin_cur || q_data.bin_err;
                cnt_reg   <= err_add(cnt_cur, {1'b0, q_data.bad} + {1'b0, q_data.bin_err});
            end else begin
                accum_reg                  <= acc_cur;
                ovf_reg                    <= ovf_cur;
                bad_reg                    <= bad_cur;
                bin_reg                    <= bin_cur;
                cnt_reg                    <= cnt_cur;
                out_reg.value              <= acc_cur;
                out_reg.base_code          <= q_data.base;
                out_reg.overflow           <= ovf_cur;
                out_reg.bad_digit          <= bad_cur;
                out_reg.binary_range_error <= bin_cur;
                out_reg.no_digits          <= no_dig;
                out_reg.error_count        <= err_add(cnt_cur, {1'b0, no_dig} + {1'b0, ovf_cur});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop && q_data.op == CMD_FINISH) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/ilp_checker.sv
// Port-level checks for the integer literal parser, bound to the top level.
module ilp_checker
    import ilp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_bin_flag_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.binary_range_error |-> m_data.base_code == BASE_BIN)
        else $error("binary range error outside binary literal");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.no_digits |-> m_data.value == '0)
        else $error("literal without digits has nonzero value");

    a_count_covers_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.error_count >= ERR_W'($countones({m_data.overflow,
            m_data.bad_digit, m_data.binary_range_error, m_data.no_digits})))
        else $error("error count below raised flags");

endmodule

bind integer_literal_parser_top ilp_checker u_ilp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/tb_integer_literal_parser_top.sv
// Self-checking testbench for the integer literal parser: byte stream in, literal results out.
module tb_integer_literal_parser_top;
    import ilp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_HIGH_MIN = 8'h80;
    localparam logic [7:0] CH_HIGH_MAX = 8'hFF;
    localparam int TARGET_ITEMS = 1600;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT = 1000;
    localparam int CALM_FROM = 400;
    localparam int CALM_TO = 700;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 50;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    integer_literal_parser_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    in_item_t  pending_bytes[$];
    out_item_t expected_literals[$];

    int n_planned = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_overflow = 0;
    int n_bad = 0;
    int n_saturated = 0;
    int n_in_stalls = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_fire = 1'b0;
    logic calm;

    assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

    // Lexer state mirrored from the byte stream.
    bit               lit_active;
    phase_e_t         lit_phase;
    base_e_t          lit_base;
    logic [31:0]      lit_accum;
    bit               lit_have;
    bit               lit_ovf;
    bit               lit_bad;
    bit               lit_binerr;
    logic [ERR_W-1:0] lit_errs;

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LZ) ||
               (c >= CH_UA && c <= CH_UZ);
    endfunction

    task automatic clear_literal();
        lit_active = 1'b0;
        lit_phase = PH_IDLE;
        lit_base = BASE_DEC;
        lit_accum = '0;
        lit_have = 1'b0;
        lit_ovf = 1'b0;
        lit_bad = 1'b0;
        lit_binerr = 1'b0;
        lit_errs = '0;
    endtask

    task automatic note_error();
        if (lit_errs != ERR_MAX) begin
            lit_errs = lit_errs + 1'b1;
        end
    endtask

    task automatic close_literal();
        out_item_t res;
        res.no_digits = !lit_have;
        if (!lit_have) begin
            note_error();
        end
        if (lit_ovf) begin
            note_error();
        end
        res.value = lit_accum;
        res.base_code = lit_base;
        res.overflow = lit_ovf;
        res.bad_digit = lit_bad;
        res.binary_range_error = lit_binerr;
        res.error_count = lit_errs;
        expected_literals.push_back(res);
        lit_active = 1'b0;
        lit_phase = PH_IDLE;
    endtask

    task automatic scan_byte(input logic [7:0] c);
        logic [63:0] radix;
        logic [63:0] digit;
        logic [63:0] limit;
        if (c == CH_APOS) begin
            return;
        end
        if (!is_alnum(c)) begin
            close_literal();
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            digit = {56'd0, c} - CH_ZERO;
        end else if (lit_base == BASE_HEX && c >= CH_LA && c <= CH_LF) begin
            digit = {56'd0, c} - CH_LA + HEX_OFFSET;
        end else if (lit_base == BASE_HEX && c >= CH_UA && c <= CH_UF) begin
            digit = {56'd0, c} - CH_UA + HEX_OFFSET;
        end else begin
            // A letter outside the base still feeds its raw code into the value.
            digit = {56'd0, c};
            lit_bad = 1'b1;
            note_error();
        end
        lit_have = 1'b1;
        if (lit_base == BASE_BIN && digit >= 2) begin
            lit_binerr = 1'b1;
            note_error();
        end
        case (lit_base)
            BASE_BIN: radix = 64'd2;
            BASE_HEX: radix = 64'd16;
            default:  radix = 64'd10;
        endcase
        limit = 64'hFFFF_FFFF;
        if ({32'd0, lit_accum} > (limit - digit) / radix) begin
            lit_ovf = 1'b1;
        end
        lit_accum = 32'(({32'd0, lit_accum} * radix + digit) & limit);
    endtask

    task automatic lex_byte(input in_item_t it);
        if (it.start_req) begin
            clear_literal();
            lit_active = 1'b1;
            if (it.ch == CH_ZERO) begin
                lit_phase = PH_ZERO;
                lit_have = 1'b1;
            end else begin
                lit_phase = PH_DIGITS;
                scan_byte(it.ch);
            end
        end else if (lit_active) begin
            if (lit_phase == PH_ZERO) begin
                lit_phase = PH_DIGITS;
                if (it.ch == CH_LB || it.ch == CH_UB) begin
                    lit_base = BASE_BIN;
                    lit_have = 1'b0;
                end else if (it.ch == CH_LX || it.ch == CH_UX) begin
                    lit_base = BASE_HEX;
                    lit_have = 1'b0;
                end else begin
                    scan_byte(it.ch);
                end
            end else begin
                scan_byte(it.ch);
            end
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (n_errors < MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
        n_errors++;
    endtask

    task automatic check_literal(input out_item_t got);
        out_item_t want;
        if (expected_literals.size() == 0) begin
            if (n_errors < MAX_REPORTS) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            end
            n_errors++;
            return;
        end
        want = expected_literals.pop_front();
        n_checked++;
        if (want.overflow) n_overflow++;
        if (want.bad_digit) n_bad++;
        if (want.error_count == ERR_MAX) n_saturated++;
        if (got.value !== want.value)
            report_field("value", want.value, got.value);
        if (got.base_code !== want.base_code)
            report_field("base_code", 32'(want.base_code), 32'(got.base_code));
        if (got.overflow !== want.overflow)
            report_field("overflow", 32'(want.overflow), 32'(got.overflow));
        if (got.bad_digit !== want.bad_digit)
            report_field("bad_digit", 32'(want.bad_digit), 32'(got.bad_digit));
        if (got.binary_range_error !== want.binary_range_error)
            report_field("binary_range_error", 32'(want.binary_range_error),
                         32'(got.binary_range_error));
        if (got.no_digits !== want.no_digits)
            report_field("no_digits", 32'(want.no_digits), 32'(got.no_digits));
        if (got.error_count !== want.error_count)
            report_field("error_count", 32'(want.error_count), 32'(got.error_count));
    endtask

    // ---------------- stimulus generation ----------------

    task automatic push_byte(input logic [7:0] c, input logic start, input bit counted);
        in_item_t it;
        it.ch = c;
        it.start_req = start;
        pending_bytes.push_back(it);
        if (counted) n_planned++;
    endtask

    function automatic logic [7:0] rand_alnum();
        int k;
        k = $urandom_range(61);
        if (k < 10) return CH_ZERO + 8'(k);
        if (k < 36) return CH_LA + 8'(k - 10);
        return CH_UA + 8'(k - 36);
    endfunction

    function automatic logic [7:0] rand_digit(input base_e_t b);
        int k;
        case (b)
            BASE_BIN: return CH_ZERO + 8'($urandom_range(1));
            BASE_HEX: begin
                k = $urandom_range(15);
                if (k < 10) return CH_ZERO + 8'(k);
                return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(k - 10);
            end
            default: return CH_ZERO + 8'($urandom_range(9));
        endcase
    endfunction

    function automatic logic [7:0] rand_terminator();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (is_alnum(c) || c == CH_APOS) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // Most literals end on a byte that is neither alphanumeric nor a separator; some on a high byte, some by a restart.
    task automatic push_end();
        int p;
        p = $urandom_range(99);
        if (p < 8) begin
            return;
        end else if (p < 20) begin
            push_byte(8'($urandom_range(CH_HIGH_MIN, CH_HIGH_MAX)), 1'b0, 1'b1);
        end else begin
            push_byte(rand_terminator(), 1'b0, 1'b1);
        end
    endtask

    task automatic push_directed();
        // Lone zero.
        push_byte(CH_ZERO, 1'b1, 1'b1);
        push_byte(CH_SPACE, 1'b0, 1'b1);
        // Hex prefix with nothing after it.
        push_byte(CH_ZERO, 1'b1, 1'b1);
        push_byte(CH_LX, 1'b0, 1'b1);
        push_byte(CH_SEMI, 1'b0, 1'b1);
        // Binary digit out of range, then a letter that is two errors in binary.
        push_byte(CH_ZERO, 1'b1, 1'b1);
        push_byte(CH_UB, 1'b0, 1'b1);
        push_byte(CH_ZERO + 8'd2, 1'b0, 1'b1);
        push_byte(CH_LZ, 1'b0, 1'b1);
        push_byte(CH_SPACE, 1'b0, 1'b1);
        // Upper prefix, mixed-case hex digits, ended by the top byte code.
        push_byte(CH_ZERO, 1'b1, 1'b1);
        push_byte(CH_UX, 1'b0, 1'b1);
        push_byte(CH_LF, 1'b0, 1'b1);
        push_byte(CH_UF, 1'b0, 1'b1);
        push_byte(CH_HIGH_MAX, 1'b0, 1'b1);
        // Separator inside a decimal literal and a letter that is no decimal digit.
        push_byte(CH_NINE, 1'b1, 1'b1);
        push_byte(CH_APOS, 1'b0, 1'b1);
        push_byte(CH_LA + 8'd6, 1'b0, 1'b1);
        push_byte(CH_HIGH_MIN, 1'b0, 1'b1);
        // Start on a punctuation byte, then start on a separator.
        push_byte(CH_SPACE, 1'b1, 1'b1);
        push_byte(CH_APOS, 1'b1, 1'b1);
        push_byte(CH_DOT, 1'b0, 1'b1);
        // Byte while idle is dropped.
        push_byte(CH_UA, 1'b0, 1'b0);
        // Restart in the middle of a literal.
        push_byte(CH_ZERO + 8'd5, 1'b1, 1'b1);
        push_byte(CH_ZERO + 8'd7, 1'b1, 1'b1);
        push_byte(CH_DOT, 1'b0, 1'b1);
    endtask

    task automatic push_random_literal();
        int r;
        int n;
        int p;
        base_e_t b;
        r = $urandom_range(99);
        if (r < 20) begin
            // Noise: random bytes, some of them starting a literal.
            n = $urandom_range(1, 6);
            repeat (n) begin
                p = $urandom_range(99);
                push_byte(8'($urandom_range(255)), p < 10, 1'b1);
            end
        end else if (r < 22) begin
            // Enough bad binary digits to saturate the error count.
            push_byte(CH_ZERO, 1'b1, 1'b1);
            push_byte($urandom_range(1) ? CH_LB : CH_UB, 1'b0, 1'b1);
            n = $urandom_range(32, 40);
            repeat (n) begin
                push_byte(($urandom_range(1) ? CH_LA : CH_UA) + 8'($urandom_range(6, 25)),
                          1'b0, 1'b1);
            end
            push_end();
        end else if (r < 25) begin
            // All-ones hex, eight digits hits the top value, nine overflow.
            push_byte(CH_ZERO, 1'b1, 1'b1);
            push_byte($urandom_range(1) ? CH_LX : CH_UX, 1'b0, 1'b1);
            n = $urandom_range(8, 9);
            repeat (n) begin
                push_byte($urandom_range(1) ? CH_LF : CH_UF, 1'b0, 1'b1);
            end
            push_end();
        end else begin
            p = $urandom_range(99);
            if (p < 30) begin
                push_byte(CH_ZERO, 1'b1, 1'b1);
                case ($urandom_range(3))
                    0: push_byte(CH_LB, 1'b0, 1'b1);
                    1: push_byte(CH_UB, 1'b0, 1'b1);
                    2: push_byte(CH_LX, 1'b0, 1'b1);
                    default: push_byte(CH_UX, 1'b0, 1'b1);
                endcase
                b = (pending_bytes[$].ch == CH_LB || pending_bytes[$].ch == CH_UB) ?
                    BASE_BIN : BASE_HEX;
            end else if (p < 42) begin
                push_byte(CH_ZERO, 1'b1, 1'b1);
                b = BASE_DEC;
            end else if (p < 48) begin
                push_byte($urandom_range(1) ? CH_APOS : rand_terminator(), 1'b1, 1'b1);
                b = BASE_DEC;
            end else begin
                push_byte(CH_ZERO + 8'($urandom_range(1, 9)), 1'b1, 1'b1);
                b = BASE_DEC;
            end
            p = $urandom_range(99);
            if (p < 4) begin
                n = $urandom_range(30, 40);
            end else if (p < 25) begin
                n = $urandom_range(9, 14);
            end else begin
                n = $urandom_range(0, 8);
            end
            repeat (n) begin
                p = $urandom_range(99);
                if (p < 8) begin
                    push_byte(CH_APOS, 1'b0, 1'b1);
                end else if (p < 16) begin
                    push_byte(rand_alnum(), 1'b0, 1'b1);
                end else begin
                    push_byte(rand_digit(b), 1'b0, 1'b1);
                end
            end
            push_end();
        end
    endtask

    // ---------------- driver and monitor ----------------

    always @(posedge aclk) begin
        in_fire = s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_literal(m_data);
            end
            if (in_fire) begin
                lex_byte(s_data);
                n_accepted++;
            end
            if (s_valid && !s_ready) begin
                n_in_stalls++;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_fire)) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 25)) begin
                s_data <= pending_bytes.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random except in the calm window, plus one long hold-off that backs up the block.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        clear_literal();
        push_directed();
        while (n_planned < TARGET_ITEMS) begin
            push_random_literal();
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        while (pending_bytes.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_literals.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_literals.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_literals.size());
            n_errors++;
        end
        $display("Checked %0d literals from %0d input bytes: %0d overflowed, %0d had bad digits,",
                 n_checked, n_accepted, n_overflow, n_bad);
        $display("%0d saturated the error count; input was held off for %0d cycles.",
                 n_saturated, n_in_stalls);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
